// ----- rtl/adi_pkg.sv -----
// ----------------------------------------------------------------------------
// adi_pkg - shared types and constants of the advection-diffusion increment core
// Operand codes, multiply-accumulate microprogram, command/status structs,
// saturation helpers.
// ----------------------------------------------------------------------------
package adi_pkg;

  // input item kinds
  localparam logic [1:0] MODE_COL  = 2'd0;
  localparam logic [1:0] MODE_ROW  = 2'd1;
  localparam logic [1:0] MODE_CELL = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_DIFFUS = 3'd0;
  localparam logic [2:0] REG_TSTEP  = 3'd1;
  localparam logic [2:0] REG_WNOW   = 3'd2;
  localparam logic [2:0] REG_WBEF   = 3'd3;
  localparam logic [2:0] REG_WIMP   = 3'd4;

  // accumulator width: three rounded products of at most 2^43 each
  localparam int AW = 48;

  // Q20 one
  localparam logic signed [31:0] Q_ONE = 32'sd1048576;

  // operand codes of the shared multiplier
  localparam logic [5:0] SRC_SW     = 6'd0;
  localparam logic [5:0] SRC_SC     = 6'd1;
  localparam logic [5:0] SRC_SE     = 6'd2;
  localparam logic [5:0] SRC_SS     = 6'd3;
  localparam logic [5:0] SRC_SN     = 6'd4;
  localparam logic [5:0] SRC_DXM    = 6'd5;
  localparam logic [5:0] SRC_DXP    = 6'd6;
  localparam logic [5:0] SRC_DYM    = 6'd7;
  localparam logic [5:0] SRC_DYP    = 6'd8;
  localparam logic [5:0] SRC_UX0    = 6'd9;
  localparam logic [5:0] SRC_UX1    = 6'd10;
  localparam logic [5:0] SRC_UYC    = 6'd11;
  localparam logic [5:0] SRC_VYN    = 6'd12;
  localparam logic [5:0] SRC_PE     = 6'd13;
  localparam logic [5:0] SRC_INVX   = 6'd14;
  localparam logic [5:0] SRC_LOX    = 6'd15;
  localparam logic [5:0] SRC_MIDX   = 6'd16;
  localparam logic [5:0] SRC_UPX    = 6'd17;
  localparam logic [5:0] SRC_INVY   = 6'd18;
  localparam logic [5:0] SRC_LOY    = 6'd19;
  localparam logic [5:0] SRC_MIDY   = 6'd20;
  localparam logic [5:0] SRC_UPY    = 6'd21;
  localparam logic [5:0] SRC_DIFFUS = 6'd22;
  localparam logic [5:0] SRC_TSTEP  = 6'd23;
  localparam logic [5:0] SRC_WNOW   = 6'd24;
  localparam logic [5:0] SRC_WBEF   = 6'd25;
  localparam logic [5:0] SRC_WIMP   = 6'd26;
  localparam logic [5:0] SRC_ONE    = 6'd27;
  localparam logic [5:0] SRC_AX     = 6'd28;
  localparam logic [5:0] SRC_AY     = 6'd29;
  localparam logic [5:0] SRC_ADVX   = 6'd30;
  localparam logic [5:0] SRC_ADVY   = 6'd31;
  localparam logic [5:0] SRC_EXPL   = 6'd32;
  localparam logic [5:0] SRC_LX     = 6'd33;
  localparam logic [5:0] SRC_LY     = 6'd34;
  localparam logic [5:0] SRC_LAP    = 6'd35;
  localparam logic [5:0] SRC_DIFF   = 6'd36;
  localparam logic [5:0] SRC_TOT    = 6'd37;
  localparam logic [5:0] SRC_INC    = 6'd38;

  localparam logic [4:0] UOP_LAST = 5'd20;

  typedef struct packed {
    logic [5:0] a_src;
    logic [5:0] b_src;
    logic       sh21;
    logic       neg;
    logic       first;
    logic       last;
    logic [5:0] dest;
  } uop_t;

  typedef struct packed {
    logic [30:0]        diffus;
    logic [30:0]        tstep;
    logic signed [31:0] wnow;
    logic signed [31:0] wbef;
    logic signed [31:0] wimp;
  } cfg_t;

  typedef struct packed {
    logic       cap_in;
    logic       rd_en;
    logic [1:0] rd_phase;
    logic       wr_line;
    logic       diff;
    logic       mul;
    logic       acc;
    logic [4:0] uop_idx;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic interior;
    logic out_busy;
  } sts_t;

  // multiply-accumulate microprogram, one product per entry
  function automatic uop_t uop_rom(input logic [4:0] idx);
    uop_t u;
    u = '{a_src: SRC_ONE, b_src: SRC_ONE, sh21: 1'b0, neg: 1'b0,
          first: 1'b1, last: 1'b0, dest: SRC_AX};
    case (idx)
      5'd0:  u = '{SRC_UX0,    SRC_DXM,  1'b0, 1'b0, 1'b1, 1'b0, SRC_AX};
      5'd1:  u = '{SRC_UX1,    SRC_DXP,  1'b0, 1'b0, 1'b0, 1'b1, SRC_AX};
      5'd2:  u = '{SRC_UYC,    SRC_DYM,  1'b0, 1'b0, 1'b1, 1'b0, SRC_AY};
      5'd3:  u = '{SRC_VYN,    SRC_DYP,  1'b0, 1'b0, 1'b0, 1'b1, SRC_AY};
      5'd4:  u = '{SRC_INVX,   SRC_AX,   1'b1, 1'b1, 1'b1, 1'b1, SRC_ADVX};
      5'd5:  u = '{SRC_INVY,   SRC_AY,   1'b1, 1'b1, 1'b1, 1'b1, SRC_ADVY};
      5'd6:  u = '{SRC_ADVX,   SRC_ONE,  1'b0, 1'b0, 1'b1, 1'b0, SRC_EXPL};
      5'd7:  u = '{SRC_ADVY,   SRC_ONE,  1'b0, 1'b0, 1'b0, 1'b1, SRC_EXPL};
      5'd8:  u = '{SRC_LOX,    SRC_SW,   1'b0, 1'b0, 1'b1, 1'b0, SRC_LX};
      5'd9:  u = '{SRC_MIDX,   SRC_SC,   1'b0, 1'b0, 1'b0, 1'b0, SRC_LX};
      5'd10: u = '{SRC_UPX,    SRC_SE,   1'b0, 1'b0, 1'b0, 1'b1, SRC_LX};
      5'd11: u = '{SRC_LOY,    SRC_SS,   1'b0, 1'b0, 1'b1, 1'b0, SRC_LY};
      5'd12: u = '{SRC_MIDY,   SRC_SC,   1'b0, 1'b0, 1'b0, 1'b0, SRC_LY};
      5'd13: u = '{SRC_UPY,    SRC_SN,   1'b0, 1'b0, 1'b0, 1'b1, SRC_LY};
      5'd14: u = '{SRC_LX,     SRC_ONE,  1'b0, 1'b0, 1'b1, 1'b0, SRC_LAP};
      5'd15: u = '{SRC_LY,     SRC_ONE,  1'b0, 1'b0, 1'b0, 1'b1, SRC_LAP};
      5'd16: u = '{SRC_DIFFUS, SRC_LAP,  1'b0, 1'b0, 1'b1, 1'b1, SRC_DIFF};
      5'd17: u = '{SRC_WNOW,   SRC_EXPL, 1'b0, 1'b0, 1'b1, 1'b0, SRC_TOT};
      5'd18: u = '{SRC_WBEF,   SRC_PE,   1'b0, 1'b0, 1'b0, 1'b0, SRC_TOT};
      5'd19: u = '{SRC_WIMP,   SRC_DIFF, 1'b0, 1'b0, 1'b0, 1'b1, SRC_TOT};
      5'd20: u = '{SRC_TSTEP,  SRC_TOT,  1'b0, 1'b0, 1'b1, 1'b1, SRC_INC};
      default: u = '{SRC_ONE,  SRC_ONE,  1'b0, 1'b0, 1'b1, 1'b0, SRC_INC};
    endcase
    return u;
  endfunction

  // clamp accumulator to signed 32 bits
  function automatic logic signed [31:0] sat_acc(input logic signed [AW-1:0] v);
    logic signed [31:0] r;
    if (v > $signed(AW'(32'sh7FFF_FFFF))) r = 32'sh7FFF_FFFF;
    else if (v < -$signed(AW'(33'sh0_8000_0000))) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // clamp a 33-bit difference to signed 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/adi_ctrl.sv -----
// ----------------------------------------------------------------------------
// adi_ctrl - sequencer of the increment core
// Steps interior cells through line reads, line write-back, differences, the
// multiply-accumulate microprogram and output load; halo cells only write back.
// ----------------------------------------------------------------------------
module adi_ctrl
  import adi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] in_mode,
  output logic       in_tready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_DIFF = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [4:0] uop_r, uop_nxt;
  logic       cell_r, cell_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    uop_nxt   = uop_r;
    cell_nxt  = cell_r;
    cmd       = '0;
    cmd.uop_idx = uop_r;
    cmd.rd_phase = phase_r[1:0];
    case (state_r)
      S_IDLE: begin
        cmd.cap_in = accept;
        if (accept && in_mode == MODE_CELL) begin
          phase_nxt = 3'd0;
          cell_nxt  = sts.interior;
          state_nxt = sts.interior ? S_RD : S_WR;
        end
      end
      S_RD: begin
        cmd.rd_en = (phase_r != 3'd4);
        phase_nxt = phase_r + 3'd1;
        if (phase_r == 3'd4) state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr_line = 1'b1;
        state_nxt = cell_r ? S_DIFF : S_IDLE;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        uop_nxt   = 5'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (uop_r == UOP_LAST) begin
          state_nxt = S_OUT;
        end else begin
          uop_nxt   = uop_r + 5'd1;
          state_nxt = S_MUL;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= 3'd0;
      uop_r   <= 5'd0;
      cell_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      uop_r   <= uop_nxt;
      cell_r  <= cell_nxt;
    end
  end

  a_rd_interior: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD && phase_r == 3'd0) |-> sts.interior)
    else $error("line read started for a halo cell");
  a_wr_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |=> (state_r == S_DIFF || state_r == S_IDLE))
    else $error("bad state after write-back");
  a_prog_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && uop_r == UOP_LAST) |=> (state_r == S_OUT))
    else $error("microprogram did not end in output");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !sts.out_busy) |=> (state_r == S_IDLE))
    else $error("output load lost");

endmodule

// ----- rtl/adi_dpath.sv -----
// ----------------------------------------------------------------------------
// adi_dpath - datapath of the increment core
// Metric and line memories, grid position, stencil registers, one shared
// 32x32 multiplier with rounding accumulator, output register.
// ----------------------------------------------------------------------------
module adi_dpath
  import adi_pkg::*;
#(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         in_mode,
  input  logic [8:0]         in_metric_index,
  input  logic signed [31:0] in_inverse_scale,
  input  logic signed [31:0] in_coef_lower,
  input  logic signed [31:0] in_coef_main,
  input  logic signed [31:0] in_coef_upper,
  input  logic signed [31:0] in_scalar_value,
  input  logic signed [31:0] in_velocity_x,
  input  logic signed [31:0] in_velocity_y,
  input  logic signed [31:0] in_previous_explicit,
  input  logic               out_tready,
  output logic               out_valid,
  output logic [8:0]         out_cell_row,
  output logic [8:0]         out_cell_column,
  output logic signed [31:0] out_increment,
  output logic signed [31:0] out_explicit_term,
  output logic               out_frame_last
);

  localparam int PADW = GRID_WIDTH + 2;
  localparam int PADH = GRID_HEIGHT + 2;
  localparam int CW   = $clog2(PADW);
  localparam int RW   = $clog2(PADH);

  // memories
  logic [127:0]       col_mem [PADW];
  logic [127:0]       row_mem [PADH];
  logic signed [31:0] scal_mem [2][PADW];
  logic signed [31:0] vx_mem [PADW];
  logic signed [31:0] vy_mem [PADW];
  logic signed [31:0] ex_mem [PADW];

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [RW-1:0] jrow;
  logic          cur_slot;

  logic signed [31:0] sn_r, vxi_r, vyi_r, pei_r;
  logic signed [31:0] scal_q_r, vx_q_r, vy_q_r, ex_q_r;
  logic [127:0]       colm_q_r, rowm_q_r, colm_r, rowm_r;
  logic               rd_v_r;
  logic [1:0]         rd_ph_r;
  logic signed [31:0] sw_r, sc_r, se_r, ss_r, ux0_r, ux1_r, uyc_r, pel_r;
  logic signed [31:0] dxm_r, dxp_r, dym_r, dyp_r;
  logic signed [31:0] ax_r, ay_r, advx_r, advy_r, expl_r, lx_r, ly_r;
  logic signed [31:0] lap_r, diff_r, tot_r, inc_r;
  logic [8:0]         orow_r, ocol_r;
  logic               olast_r;
  logic               out_valid_r;

  uop_t               uop, uop_r;
  logic signed [31:0] a_val, b_val;
  logic signed [63:0] prod_r;
  logic [63:0]        mag;
  logic [63:0]        rnd;
  logic signed [AW-1:0] term, acc_r, acc_nxt;
  logic               col_ok, row_ok;
  logic [CW-1:0]      rd_col;
  logic               rd_slot;

  assign jrow     = row_r - RW'(1);
  assign cur_slot = row_r[0];
  assign col_ok   = 32'(in_metric_index) < 32'(PADW);
  assign row_ok   = 32'(in_metric_index) < 32'(PADH);

  assign sts.interior = (row_r >= RW'(2)) && (col_r >= CW'(1)) &&
                        (col_r <= CW'(GRID_WIDTH));
  assign sts.out_busy = out_valid_r && !out_tready;

  // metric stores, written on load requests
  always_ff @(posedge clk) begin
    if (cmd.cap_in && in_mode == MODE_COL && col_ok)
      col_mem[CW'(in_metric_index)] <= {in_inverse_scale, in_coef_lower,
                                        in_coef_main, in_coef_upper};
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in && in_mode == MODE_ROW && row_ok)
      row_mem[RW'(in_metric_index)] <= {in_inverse_scale, in_coef_lower,
                                        in_coef_main, in_coef_upper};
  end

  // hold the cell fields of the current request
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      sn_r   <= in_scalar_value;
      vxi_r  <= in_velocity_x;
      vyi_r  <= in_velocity_y;
      pei_r  <= in_previous_explicit;
    end
  end

  // read address of the scalar line per phase
  always_comb begin
    rd_slot = ~cur_slot;
    rd_col  = col_r;
    case (cmd.rd_phase)
      2'd0: rd_col = col_r - CW'(1);
      2'd1: rd_col = col_r;
      2'd2: rd_col = col_r + CW'(1);
      2'd3: begin
        rd_slot = cur_slot;
        rd_col  = col_r;
      end
      default: rd_col = col_r;
    endcase
  end

  // registered line and metric reads
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      scal_q_r <= scal_mem[rd_slot][rd_col];
      vx_q_r   <= vx_mem[(cmd.rd_phase == 2'd0) ? col_r : col_r + CW'(1)];
      vy_q_r   <= vy_mem[col_r];
      ex_q_r   <= ex_mem[col_r];
      colm_q_r <= col_mem[col_r];
      rowm_q_r <= row_mem[jrow];
    end
  end

  // line write-back
  always_ff @(posedge clk) begin
    if (cmd.wr_line) scal_mem[cur_slot][col_r] <= sn_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_line) begin
      vx_mem[col_r] <= vxi_r;
      vy_mem[col_r] <= vyi_r;
      ex_mem[col_r] <= pei_r;
    end
  end

  // spread read data into the stencil registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.rd_en;
    end
    rd_ph_r <= cmd.rd_phase;
    if (rd_v_r) begin
      case (rd_ph_r)
        2'd0: begin
          sw_r   <= scal_q_r;
          ux0_r  <= vx_q_r;
          uyc_r  <= vy_q_r;
          pel_r  <= ex_q_r;
          colm_r <= colm_q_r;
          rowm_r <= rowm_q_r;
        end
        2'd1: begin
          sc_r  <= scal_q_r;
          ux1_r <= vx_q_r;
        end
        2'd2: se_r <= scal_q_r;
        2'd3: ss_r <= scal_q_r;
        default: se_r <= se_r;
      endcase
    end
  end

  // grid position; latch report coordinates before advancing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.wr_line) begin
      if (col_r == CW'(PADW - 1)) begin
        col_r <= '0;
        row_r <= (row_r == RW'(PADH - 1)) ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_line) begin
      orow_r  <= 9'(jrow);
      ocol_r  <= 9'(col_r);
      olast_r <= (row_r == RW'(GRID_HEIGHT + 1)) && (col_r == CW'(GRID_WIDTH));
    end
  end

  // neighbor differences
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dxm_r <= sat33(33'(sc_r) - 33'(sw_r));
      dxp_r <= sat33(33'(se_r) - 33'(sc_r));
      dym_r <= sat33(33'(sc_r) - 33'(ss_r));
      dyp_r <= sat33(33'(sn_r) - 33'(sc_r));
    end
  end

  // operand select
  function automatic logic signed [31:0] pick(input logic [5:0] code);
    logic signed [31:0] v;
    case (code)
      SRC_SW:     v = sw_r;
      SRC_SC:     v = sc_r;
      SRC_SE:     v = se_r;
      SRC_SS:     v = ss_r;
      SRC_SN:     v = sn_r;
      SRC_DXM:    v = dxm_r;
      SRC_DXP:    v = dxp_r;
      SRC_DYM:    v = dym_r;
      SRC_DYP:    v = dyp_r;
      SRC_UX0:    v = ux0_r;
      SRC_UX1:    v = ux1_r;
      SRC_UYC:    v = uyc_r;
      SRC_VYN:    v = vyi_r;
      SRC_PE:     v = pel_r;
      SRC_INVX:   v = colm_r[127:96];
      SRC_LOX:    v = colm_r[95:64];
      SRC_MIDX:   v = colm_r[63:32];
      SRC_UPX:    v = colm_r[31:0];
      SRC_INVY:   v = rowm_r[127:96];
      SRC_LOY:    v = rowm_r[95:64];
      SRC_MIDY:   v = rowm_r[63:32];
      SRC_UPY:    v = rowm_r[31:0];
      SRC_DIFFUS: v = $signed({1'b0, cfg.diffus});
      SRC_TSTEP:  v = $signed({1'b0, cfg.tstep});
      SRC_WNOW:   v = cfg.wnow;
      SRC_WBEF:   v = cfg.wbef;
      SRC_WIMP:   v = cfg.wimp;
      SRC_ONE:    v = Q_ONE;
      SRC_AX:     v = ax_r;
      SRC_AY:     v = ay_r;
      SRC_ADVX:   v = advx_r;
      SRC_ADVY:   v = advy_r;
      SRC_EXPL:   v = expl_r;
      SRC_LX:     v = lx_r;
      SRC_LY:     v = ly_r;
      SRC_LAP:    v = lap_r;
      SRC_DIFF:   v = diff_r;
      SRC_TOT:    v = tot_r;
      SRC_INC:    v = inc_r;
      default:    v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    uop   = uop_rom(cmd.uop_idx);
    a_val = pick(uop.a_src);
    b_val = pick(uop.b_src);
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= a_val * b_val;
      uop_r  <= uop;
    end
  end

  // round half away from zero, shift, accumulate
  always_comb begin
    mag = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
    rnd = uop_r.sh21 ? ((mag + 64'd1048576) >> 21) : ((mag + 64'd524288) >> 20);
    term = (prod_r[63] ^ uop_r.neg) ? -$signed(rnd[AW-1:0]) : $signed(rnd[AW-1:0]);
    acc_nxt = (uop_r.first ? '0 : acc_r) + term;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      acc_r <= acc_nxt;
      if (uop_r.last) begin
        case (uop_r.dest)
          SRC_AX:   ax_r   <= sat_acc(acc_nxt);
          SRC_AY:   ay_r   <= sat_acc(acc_nxt);
          SRC_ADVX: advx_r <= sat_acc(acc_nxt);
          SRC_ADVY: advy_r <= sat_acc(acc_nxt);
          SRC_EXPL: expl_r <= sat_acc(acc_nxt);
          SRC_LX:   lx_r   <= sat_acc(acc_nxt);
          SRC_LY:   ly_r   <= sat_acc(acc_nxt);
          SRC_LAP:  lap_r  <= sat_acc(acc_nxt);
          SRC_DIFF: diff_r <= sat_acc(acc_nxt);
          SRC_TOT:  tot_r  <= sat_acc(acc_nxt);
          SRC_INC:  inc_r  <= sat_acc(acc_nxt);
          default:  inc_r  <= inc_r;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_cell_row      <= orow_r;
      out_cell_column   <= ocol_r;
      out_increment     <= inc_r;
      out_explicit_term <= expl_r;
      out_frame_last    <= olast_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/advection_diffusion_increment_core.sv -----
// ----------------------------------------------------------------------------
// advection_diffusion_increment_core - stencil increment engine, stretched grid
// Register file, sequencer and datapath of the advection-diffusion increment.
//
//   channel  dir  handshake         payload
//   in_      in   tvalid/tready     tuser: mode; tdata: metric and cell fields
//   out_     out  tvalid/tready     tdata: row, column, increment, explicit;
//                                   tlast: frame_last
//   cfg_     in   APB psel/penable  five registers of up to 32 bits at 4*index
//
// Metric loads and unused modes end in the idle state; halo and first-row
// cells only write back. Interior cells add line reads and 21 products on one
// shared multiplier, each multiplied and summed. Reset is synchronous; line
// stores need no clearing pass since the first two rows of a frame fill them.
// A finished result waits in the output register while further requests are
// taken; the core stalls only when a second result is ready before it drains.
// ----------------------------------------------------------------------------
module advection_diffusion_increment_core
  import adi_pkg::*;
#(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [8:0] metric_index, [40:9] inverse_scale, [72:41] coef_lower,
  // [104:73] coef_main, [136:105] coef_upper, [168:137] scalar_value,
  // [200:169] velocity_x, [232:201] velocity_y, [264:233] previous_explicit
  input  logic [271:0] in_tdata,
  // [1:0] mode
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [8:0] cell_row, [17:9] cell_column, [49:18] increment, [81:50] explicit_term
  output logic [87:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  cfg_t               cfg_r;
  cmd_t               cmd;
  sts_t               sts;
  logic [2:0]         reg_idx;
  logic               cfg_wr;
  logic [8:0]         o_row, o_col;
  logic signed [31:0] o_inc, o_expl;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DIFFUS: cfg_r.diffus <= cfg_pwdata[30:0];
        REG_TSTEP:  cfg_r.tstep  <= cfg_pwdata[30:0];
        REG_WNOW:   cfg_r.wnow   <= cfg_pwdata;
        REG_WBEF:   cfg_r.wbef   <= cfg_pwdata;
        REG_WIMP:   cfg_r.wimp   <= cfg_pwdata;
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_DIFFUS: cfg_prdata = {1'b0, cfg_r.diffus};
      REG_TSTEP:  cfg_prdata = {1'b0, cfg_r.tstep};
      REG_WNOW:   cfg_prdata = cfg_r.wnow;
      REG_WBEF:   cfg_prdata = cfg_r.wbef;
      REG_WIMP:   cfg_prdata = cfg_r.wimp;
      default:    cfg_prdata = '0;
    endcase
  end

  adi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  adi_dpath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_mode              (in_tuser),
    .in_metric_index      (in_tdata[8:0]),
    .in_inverse_scale     (in_tdata[40:9]),
    .in_coef_lower        (in_tdata[72:41]),
    .in_coef_main         (in_tdata[104:73]),
    .in_coef_upper        (in_tdata[136:105]),
    .in_scalar_value      (in_tdata[168:137]),
    .in_velocity_x        (in_tdata[200:169]),
    .in_velocity_y        (in_tdata[232:201]),
    .in_previous_explicit (in_tdata[264:233]),
    .out_tready           (out_tready),
    .out_valid            (out_tvalid),
    .out_cell_row         (o_row),
    .out_cell_column      (o_col),
    .out_increment        (o_inc),
    .out_explicit_term    (o_expl),
    .out_frame_last       (out_tlast)
  );

  assign out_tdata = {6'd0, o_expl, o_inc, o_col, o_row};

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - advection-diffusion increment core regression
// Loads column and row metrics, streams padded-grid cells in raster order
// through several register settings and compares every reported cell
// against a stencil predictor kept inside the bench, under random idling.
// ----------------------------------------------------------------------------
module testbench;
  import adi_pkg::*;

  localparam int GW = 256;
  localparam int GH = 256;
  localparam int PW = GW + 2;
  localparam int PH = GH + 2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 100000;

  typedef struct {
    logic [1:0]         mode;
    logic [8:0]         idx;
    logic signed [31:0] inv, lo, mid, up;
    logic signed [31:0] sv, vx, vy, pe;
  } request_t;

  typedef struct {
    logic [8:0]         row, col;
    logic signed [31:0] inc, expl;
    logic               last;
  } report_t;

  typedef struct {
    longint inv, lo, mid, up;
  } metric_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [271:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [87:0]  out_tdata;
  logic         out_tlast;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  advection_diffusion_increment_core #(.GRID_WIDTH(GW), .GRID_HEIGHT(GH)) i_dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // stencil predictor state
  longint  diffus_q, tstep_q, wnow_q, wbef_q, wimp_q;
  metric_t col_metric [PW];
  metric_t row_metric [PH];
  longint  scalar_rows [2][PW];
  longint  ux_row [PW];
  longint  uy_row [PW];
  longint  expl_row [PW];
  int      cur_row, cur_col;

  request_t requests_pending [$];
  report_t  reports_due [$];
  request_t offered;
  int       cycles = 0;
  int       mismatches = 0;
  int       reports_seen = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // exact product, scaled down with rounding half away from zero
  function automatic longint scale_mul(longint a, longint b, int sh);
    longint p;
    longint unsigned m, r;
    p = a * b;
    m = (p < 0) ? longint'(-p) : p;
    r = (m + (64'd1 << (sh - 1))) >> sh;
    return (p < 0) ? -longint'(r) : longint'(r);
  endfunction

  // advance the predicted stencil by one accepted request
  task automatic step_stencil(input request_t q);
    int      cu, pv, j, c;
    longint  sc, sw, se, ss, sn, dxm, dxp, dym, dyp, ax, ay, ex, lx, ly, df, tot;
    report_t rp;
    c = cur_col;
    cu = cur_row & 1;
    pv = (cur_row + 1) & 1;
    if (q.mode == MODE_COL) begin
      if (q.idx < PW) col_metric[q.idx] = '{q.inv, q.lo, q.mid, q.up};
      return;
    end
    if (q.mode == MODE_ROW) begin
      if (q.idx < PH) row_metric[q.idx] = '{q.inv, q.lo, q.mid, q.up};
      return;
    end
    if (q.mode != MODE_CELL) return;
    if (cur_row >= 2 && c >= 1 && c <= GW) begin
      j = cur_row - 1;
      sc = scalar_rows[pv][c];
      sw = scalar_rows[pv][c-1];
      se = scalar_rows[pv][c+1];
      ss = scalar_rows[cu][c];
      sn = q.sv;
      dxm = clamp32(sc - sw);
      dxp = clamp32(se - sc);
      dym = clamp32(sc - ss);
      dyp = clamp32(sn - sc);
      ax = clamp32(scale_mul(ux_row[c], dxm, 20) + scale_mul(ux_row[c+1], dxp, 20));
      ay = clamp32(scale_mul(uy_row[c], dym, 20) + scale_mul(q.vy, dyp, 20));
      ex = clamp32(clamp32(-scale_mul(col_metric[c].inv, ax, 21))
                   + clamp32(-scale_mul(row_metric[j].inv, ay, 21)));
      lx = clamp32(scale_mul(col_metric[c].lo, sw, 20) + scale_mul(col_metric[c].mid, sc, 20)
                   + scale_mul(col_metric[c].up, se, 20));
      ly = clamp32(scale_mul(row_metric[j].lo, ss, 20) + scale_mul(row_metric[j].mid, sc, 20)
                   + scale_mul(row_metric[j].up, sn, 20));
      df = clamp32(scale_mul(diffus_q, clamp32(lx + ly), 20));
      tot = clamp32(scale_mul(wnow_q, ex, 20) + scale_mul(wbef_q, expl_row[c], 20)
                    + scale_mul(wimp_q, df, 20));
      rp.row = j[8:0];
      rp.col = c[8:0];
      rp.inc = 32'(clamp32(scale_mul(tstep_q, tot, 20)));
      rp.expl = 32'(ex);
      rp.last = (j == GH && c == GW);
      reports_due.push_back(rp);
    end
    scalar_rows[cu][c] = q.sv;
    ux_row[c] = q.vx;
    uy_row[c] = q.vy;
    expl_row[c] = q.pe;
    cur_col++;
    if (cur_col >= PW) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= PH) cur_row = 0;
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4, 5: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic request_t make_request(logic [1:0] mode, logic [8:0] idx);
    request_t q;
    q.mode = mode;
    q.idx = idx;
    q.inv = pick_word();
    q.lo = pick_word();
    q.mid = pick_word();
    q.up = pick_word();
    q.sv = pick_word();
    q.vx = pick_word();
    q.vy = pick_word();
    q.pe = pick_word();
    return q;
  endfunction

  // cells in raster order, with a few reloads and ignored requests mixed in
  task automatic push_cells(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 39))
        0: requests_pending.push_back(make_request(MODE_COL, 9'($urandom_range(0, PW - 1))));
        1: requests_pending.push_back(make_request(MODE_ROW, 9'($urandom_range(0, PH - 1))));
        2: requests_pending.push_back(make_request(MODE_SPARE, 9'($urandom)));
        3: requests_pending.push_back(make_request(MODE_COL, 9'($urandom_range(PW, 511))));
        default: ;
      endcase
      requests_pending.push_back(make_request(MODE_CELL, 9'($urandom)));
    end
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {index, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    while (!cfg_pready) @(posedge clk);
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (index)
      REG_DIFFUS: diffus_q = longint'(value & 32'h7FFF_FFFF);
      REG_TSTEP:  tstep_q = longint'(value & 32'h7FFF_FFFF);
      REG_WNOW:   wnow_q = longint'($signed(value));
      REG_WBEF:   wbef_q = longint'($signed(value));
      default:    wimp_q = longint'($signed(value));
    endcase
  endtask

  task automatic load_settings(input logic [31:0] d, t, wn, wb, wi);
    write_reg(REG_DIFFUS, d);
    write_reg(REG_TSTEP, t);
    write_reg(REG_WNOW, wn);
    write_reg(REG_WBEF, wb);
    write_reg(REG_WIMP, wi);
  endtask

  task automatic wait_drained(input int tail);
    while (requests_pending.size() != 0 || in_tvalid || reports_due.size() != 0)
      @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  function automatic bit calm_window();
    return cycles >= 2000 && cycles < 5000;
  endfunction

  // sequence: reset, metrics, then cell phases under different settings
  initial begin
    request_t q;
    int k;
    diffus_q = 0; tstep_q = 0; wnow_q = 0; wbef_q = 0; wimp_q = 0;
    cur_row = 0; cur_col = 0;
    for (k = 0; k < PW; k++) begin
      col_metric[k] = '{0, 0, 0, 0};
      row_metric[k] = '{0, 0, 0, 0};
      scalar_rows[0][k] = 0; scalar_rows[1][k] = 0;
      ux_row[k] = 0; uy_row[k] = 0; expl_row[k] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    load_settings(32'h0010_0000, 32'h0008_0000, 32'h0018_0000, 32'hFFF8_0000, 32'h0010_0000);

    // directed: extreme metric words, ignored mode, out-of-range indexes
    q = make_request(MODE_COL, 9'd0);
    q.inv = 32'h7FFF_FFFF; q.lo = 32'h8000_0000; q.mid = 32'h7FFF_FFFF; q.up = 32'h8000_0000;
    requests_pending.push_back(q);
    q.inv = 32'h8000_0000; q.lo = 32'h7FFF_FFFF; q.mid = 32'h8000_0000; q.up = 32'h7FFF_FFFF;
    q.mode = MODE_ROW;
    requests_pending.push_back(q);
    requests_pending.push_back(make_request(MODE_SPARE, 9'd257));
    requests_pending.push_back(make_request(MODE_COL, 9'd258));
    requests_pending.push_back(make_request(MODE_ROW, 9'h1FF));
    for (k = 0; k < PW; k++) requests_pending.push_back(make_request(MODE_COL, 9'(k)));
    for (k = 0; k < 8; k++) requests_pending.push_back(make_request(MODE_ROW, 9'(k)));
    q = make_request(MODE_ROW, 9'd257);
    requests_pending.push_back(q);
    push_cells(530);
    wait_drained(80);

    load_settings(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_cells(40);
    wait_drained(80);

    load_settings(32'h0000_0000, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_cells(30);
    wait_drained(80);

    load_settings($urandom_range(0, 32'h0100_0000), $urandom_range(0, 32'h0020_0000),
                  pick_word(), pick_word(), pick_word());
    push_cells(20);
    wait_drained(200);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // driver: offer pending requests, predict on acceptance
  always @(posedge clk) begin
    logic nxt_valid;
    nxt_valid = in_tvalid;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        step_stencil(offered);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && requests_pending.size() != 0
          && (calm_window() || $urandom_range(0, 99) >= 16)) begin
        offered = requests_pending.pop_front();
        in_tdata <= {7'd0, offered.pe, offered.vy, offered.vx, offered.sv, offered.up,
                     offered.mid, offered.lo, offered.inv, offered.idx};
        in_tuser <= offered.mode;
        nxt_valid = 1'b1;
      end
    end
    in_tvalid <= nxt_valid;
  end

  // monitor: random ready with one long hold-off, compare reports in order
  always @(posedge clk) begin
    report_t rp;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        reports_seen++;
        if (reports_due.size() == 0) begin
          mismatches++;
          $display("%0t unexpected report: expected none, actual %h last %b",
                   $time, out_tdata, out_tlast);
        end else begin
          rp = reports_due.pop_front();
          if (out_tdata[8:0] !== rp.row || out_tdata[17:9] !== rp.col
              || out_tdata[49:18] !== rp.inc || out_tdata[81:50] !== rp.expl
              || out_tlast !== rp.last) begin
            mismatches++;
            $display("%0t report mismatch: expected row %0d col %0d inc %h expl %h last %b",
                     $time, rp.row, rp.col, rp.inc, rp.expl, rp.last);
            $display("%0t                  actual row %0d col %0d inc %h expl %h last %b",
                     $time, out_tdata[8:0], out_tdata[17:9], out_tdata[49:18],
                     out_tdata[81:50], out_tlast);
          end
        end
      end
      if (!hold_done && reports_seen == 30) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        out_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm_window() || $urandom_range(0, 99) >= 16;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
rtl/adi_pkg.sv
rtl/adi_ctrl.sv
rtl/adi_dpath.sv
rtl/advection_diffusion_increment_core.sv
tb/testbench.sv
